>>> hw/rtl/mm_pkg.sv
package mm_pkg;

    // Field widths fixed by the stream format
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 3;
    localparam int DIM_W    = 4;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top level parameters
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_NONE    = 2'd3
    } mm_req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_B_COLS    = 2'd2,
        CFG_UNUSED    = 2'd3
    } mm_cfg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic             acc_clear;
        logic             out_load;
        logic             out_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
    } mm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } mm_status_t;

endpackage

>>> hw/rtl/mm_ram.sv
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/mm_datapath.sv
module mm_datapath
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mm_cmd_t           cmd,
    output mm_status_t        status,
    input  logic [IDX_W-1:0]  ld_row,
    input  logic [IDX_W-1:0]  ld_col,
    input  logic [DATA_W-1:0] ld_value,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic              m_tlast,
    output logic [IDX_W-1:0]  out_row,
    output logic [IDX_W-1:0]  out_col,
    output logic [DATA_W-1:0] out_value,
    output logic              out_sat
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * DATA_W;
    // room for MAX_DIM full-scale products
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM + 1);
    localparam int TOP_W  = ACC_W - DATA_W + 1;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_rd_addr;
    logic [ADDR_W-1:0] b_rd_addr;
    logic [DATA_W-1:0] a_rd_data;
    logic [DATA_W-1:0] b_rd_data;

    logic                     rd_valid_reg;
    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  shifted;
    logic [TOP_W-1:0]         top_bits;
    logic                     fits;
    logic [DATA_W-1:0]        sat_value;

    logic              out_valid_reg;
    logic              out_last_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_sat_reg;

    // element address = row * MAX_DIM + column
    assign wr_addr   = ADDR_W'(ld_row) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_col);
    assign a_rd_addr = ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.k);
    assign b_rd_addr = ADDR_W'(cmd.k) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col);

    mm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_a),
        .wr_addr (wr_addr),
        .wr_data (ld_value),
        .rd_en   (cmd.rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_b),
        .wr_addr (wr_addr),
        .wr_data (ld_value),
        .rd_en   (cmd.rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // scale back to Q16.16 (floor) and clip
    assign shifted   = acc_reg >>> FRAC_BITS;
    assign top_bits  = shifted[ACC_W-1:DATA_W-1];
    assign fits      = (top_bits == '0) || (top_bits == '1);
    assign sat_value = acc_reg[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg   <= cmd.rd_en;
            prod_valid_reg <= rd_valid_reg;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end

        prod_reg <= $signed(a_rd_data) * $signed(b_rd_data);

        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end

        if (cmd.out_load) begin
            out_last_reg  <= cmd.out_last;
            out_row_reg   <= cmd.row;
            out_col_reg   <= cmd.col;
            out_value_reg <= fits ? shifted[DATA_W-1:0] : sat_value;
            out_sat_reg   <= !fits;
        end
    end

    assign status.pipe_busy = rd_valid_reg | prod_valid_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_sat   = out_sat_reg;

endmodule

>>> hw/rtl/mm_controller.sv
module mm_controller
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [IDX_W-1:0]     ld_row,
    input  logic [IDX_W-1:0]     ld_col,
    input  mm_status_t           status,
    output mm_cmd_t              cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } state_t;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] a_rows_reg, inner_dim_reg, b_cols_reg;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [DIM_W-1:0] nr, nk, nc;
    logic             accept;
    logic             a_in_range, b_in_range;
    logic             k_last, j_last, i_last;

    // registers above MAX_DIM act as MAX_DIM
    assign nr = (a_rows_reg    > DIM_MAX) ? DIM_MAX : a_rows_reg;
    assign nk = (inner_dim_reg > DIM_MAX) ? DIM_MAX : inner_dim_reg;
    assign nc = (b_cols_reg    > DIM_MAX) ? DIM_MAX : b_cols_reg;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign a_in_range = ({1'b0, ld_row} < nr) && ({1'b0, ld_col} < nk);
    assign b_in_range = ({1'b0, ld_row} < nk) && ({1'b0, ld_col} < nc);

    assign k_last = ({1'b0, k_reg} + 1'b1) == nk;
    assign j_last = ({1'b0, j_reg} + 1'b1) == nc;
    assign i_last = ({1'b0, i_reg} + 1'b1) == nr;

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        cmd           = '0;
        cmd.row       = i_reg;
        cmd.col       = j_reg;
        cmd.k         = k_reg;
        cmd.out_last  = i_last && j_last;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (req_type)
                        REQ_LOAD_A: cmd.wr_a = a_in_range;
                        REQ_LOAD_B: cmd.wr_b = b_in_range;
                        REQ_COMPUTE: begin
                            if (nr != '0 && nc != '0) begin
                                i_next        = '0;
                                j_next        = '0;
                                k_next        = '0;
                                cmd.acc_clear = 1'b1;
                                state_next    = (nk == '0) ? ST_DRAIN : ST_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                cmd.rd_en = 1'b1;
                if (k_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // wait for the last product to land and the output slot to free
                if (!status.pipe_busy && status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.acc_clear = 1'b1;
                    k_next        = '0;
                    if (i_last && j_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        if (j_last) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                        state_next = (nk == '0) ? ST_DRAIN : ST_MAC;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            a_rows_reg    <= DIM_W'(8);
            inner_dim_reg <= DIM_W'(8);
            b_cols_reg    <= DIM_W'(8);
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_A_ROWS:    a_rows_reg    <= cfg_data;
                    CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                    CFG_B_COLS:    b_cols_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/matrix_multiply_unit.sv
// Channel  | Dir | Payload
// ---------+-----+---------------------------------------------------------
// s_axis   | in  | tuser: req_type; tdata: row_index, col_index, element_value
// m_axis   | out | tuser: saturated; tlast: last;
//          |     | tdata: out_row, out_col, product_value
// cfg      | in  | cfg_index selects a_rows, inner_dim, b_cols; cfg_data 4 bits
//
// A compute emits a_rows * b_cols results, each made of one store read per
// multiply-accumulate step (no steps with inner_dim zero), a pipeline drain
// and one output load. s_tready is high only between computes; a stalled
// m_tready holds the next element in the drain step. Reset is synchronous
// and clears control state; the stores are not cleared, so elements must be
// loaded before use.
module matrix_multiply_unit
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // row_index, col_index, element_value
    input  logic [REQ_W-1:0]     s_tuser,   // req_type

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_row, out_col, product_value
    output logic                 m_tuser,   // saturated
    output logic                 m_tlast
);

    mm_cmd_t           cmd;
    mm_status_t        status;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic [DATA_W-1:0] out_value;

    mm_controller #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_type  (s_tuser),
        .ld_row    (s_tdata[2:0]),
        .ld_col    (s_tdata[5:3]),
        .status    (status),
        .cmd       (cmd)
    );

    mm_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .ld_row    (s_tdata[2:0]),
        .ld_col    (s_tdata[5:3]),
        .ld_value  (s_tdata[37:6]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_sat   (m_tuser)
    );

    assign m_tdata = {2'b00, out_value, out_col, out_row};

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mm_pkg::*;

    localparam int DIM_MAX       = MAX_DIM_DEF;
    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int STORE_WORDS   = DIM_MAX * DIM_MAX;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASE_ITEMS   = 25;
    localparam int MAX_PRINTS    = 50;
    localparam int RUN_LIMIT_NS  = 8_000_000;

    localparam logic signed [71:0] Q_MAX = 72'sh7FFF_FFFF;
    localparam logic signed [71:0] Q_MIN = -72'sh8000_0000;

    typedef struct {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              sat;
        logic              last;
    } product_t;

    typedef struct {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  inner;
        logic [DIM_W-1:0]  cols;
        mm_req_t           req;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        bit                typed;
        logic [DATA_W-1:0] want_value;
        logic              want_sat;
    } dir_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // row_index, col_index, element_value
    logic [REQ_W-1:0]     s_tuser   = '0;   // req_type
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // out_row, out_col, product_value
    logic                 m_tuser;          // saturated
    logic                 m_tlast;

    // Mirror of the block: stores, written flags, size registers
    product_t          pending_products[$];
    logic [DATA_W-1:0] a_mirror [STORE_WORDS];
    logic [DATA_W-1:0] b_mirror [STORE_WORDS];
    bit                a_loaded [STORE_WORDS];
    bit                b_loaded [STORE_WORDS];
    logic [DIM_W-1:0]  rows_reg  = 4'd8;
    logic [DIM_W-1:0]  inner_reg = 4'd8;
    logic [DIM_W-1:0]  cols_reg  = 4'd8;

    product_t typed_product;
    bit       use_typed = 1'b0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int product_count  = 0;
    int sat_count      = 0;
    int compute_count  = 0;
    int active_items   = 0;

    matrix_multiply_unit #(
        .MAX_DIM   (MAX_DIM_DEF),
        .FRAC_BITS (FRAC_BITS_DEF)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] r);
        return (r > DIM_MAX) ? DIM_MAX : int'(r);
    endfunction

    // Updates the mirror for one transfer and queues the product elements it causes
    function automatic void predict_item(mm_req_t req, logic [IDX_W-1:0] row,
                                         logic [IDX_W-1:0] col, logic [DATA_W-1:0] value);
        int unsigned       nr;
        int unsigned       nk;
        int unsigned       nc;
        logic signed [71:0] acc;
        logic signed [63:0] term;
        product_t          res;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        case (req)
            REQ_LOAD_A: begin
                if (row < nr && col < nk) begin
                    a_mirror[row * DIM_MAX + col] = value;
                    a_loaded[row * DIM_MAX + col] = 1'b1;
                    active_items++;
                end
            end
            REQ_LOAD_B: begin
                if (row < nk && col < nc) begin
                    b_mirror[row * DIM_MAX + col] = value;
                    b_loaded[row * DIM_MAX + col] = 1'b1;
                    active_items++;
                end
            end
            REQ_COMPUTE: begin
                active_items++;
                compute_count++;
                for (int i = 0; i < nr; i++) begin
                    for (int j = 0; j < nc; j++) begin
                        acc = '0;
                        for (int k = 0; k < nk; k++) begin
                            term = $signed(a_mirror[i * DIM_MAX + k]) *
                                   $signed(b_mirror[k * DIM_MAX + j]);
                            acc += term;
                        end
                        acc = acc >>> FRAC;     // floor toward minus infinity
                        res.row   = IDX_W'(i);
                        res.col   = IDX_W'(j);
                        res.sat   = (acc > Q_MAX) || (acc < Q_MIN);
                        res.value = (acc > Q_MAX) ? 32'h7FFF_FFFF :
                                    (acc < Q_MIN) ? 32'h8000_0000 : acc[DATA_W-1:0];
                        res.last  = (i == nr - 1) && (j == nc - 1);
                        pending_products.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_element();
        logic [DATA_W-1:0] mag;
        if ($urandom_range(3) == 0)
            return $urandom();
        // mostly small magnitudes so that sums stay in range
        mag = $urandom_range(32'h0004_0000);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)
            return '0;
        if (pick < 78)
            return DIM_W'($urandom_range(3, 1));
        if (pick < 93)
            return DIM_W'($urandom_range(8, 4));
        return DIM_W'($urandom_range(15, 9));
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch on %s: expected 0x%h, got 0x%h at %0t", field, want, got, $time);
        mismatch_count++;
    endtask

    // Entered and left just after a rising edge; s_tvalid stays up after the transfer
    task automatic send_item(mm_req_t req, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             logic [DATA_W-1:0] value);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({value, col, row});
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = (s_tready === 1'b1);
            @(posedge aclk);
        end
        if (use_typed) begin
            pending_products.push_back(typed_product);
            compute_count++;
            active_items++;
            use_typed = 1'b0;
        end else begin
            predict_item(req, row, col, value);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_products.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(mm_cfg_idx_t idx, logic [DIM_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        case (idx)
            CFG_A_ROWS:    rows_reg  = v;
            CFG_INNER_DIM: inner_reg = v;
            CFG_B_COLS:    cols_reg  = v;
            default: ;
        endcase
    endtask

    task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
        wait_drained();
        // loads leave nothing to wait on, so give the block time to settle
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(CFG_A_ROWS, r);
        write_reg(CFG_INNER_DIM, k);
        write_reg(CFG_B_COLS, c);
        write_reg(CFG_UNUSED, DIM_W'($urandom_range(15)));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Loads every element a compute at the current sizes would read but is still unwritten
    task automatic fill_missing();
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        for (int r = 0; r < nr; r++)
            for (int k = 0; k < nk; k++)
                if (!a_loaded[r * DIM_MAX + k])
                    send_item(REQ_LOAD_A, IDX_W'(r), IDX_W'(k), rand_element());
        for (int k = 0; k < nk; k++)
            for (int c = 0; c < nc; c++)
                if (!b_loaded[k * DIM_MAX + c])
                    send_item(REQ_LOAD_B, IDX_W'(k), IDX_W'(c), rand_element());
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Sampled mid-cycle: these values are the ones the next rising edge sees
    always @(negedge aclk) begin
        product_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_products.size() == 0) begin
                report_mismatch("product with none expected", '0,
                                m_tdata[2*IDX_W+DATA_W-1:2*IDX_W]);
            end else begin
                want = pending_products.pop_front();
                product_count++;
                if (m_tuser)
                    sat_count++;
                if (m_tdata[IDX_W-1:0] !== want.row)
                    report_mismatch("out_row", DATA_W'(want.row), DATA_W'(m_tdata[IDX_W-1:0]));
                if (m_tdata[2*IDX_W-1:IDX_W] !== want.col)
                    report_mismatch("out_col", DATA_W'(want.col),
                                    DATA_W'(m_tdata[2*IDX_W-1:IDX_W]));
                if (m_tdata[2*IDX_W+DATA_W-1:2*IDX_W] !== want.value)
                    report_mismatch("product_value", want.value,
                                    m_tdata[2*IDX_W+DATA_W-1:2*IDX_W]);
                if (m_tuser !== want.sat)
                    report_mismatch("saturated", DATA_W'(want.sat), DATA_W'(m_tuser));
                if (m_tlast !== want.last)
                    report_mismatch("last", DATA_W'(want.last), DATA_W'(m_tlast));
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        dir_row_t         directed [25];
        int unsigned      nr;
        int unsigned      nk;
        int unsigned      nc;
        int               phase_goal;
        int unsigned      pick;
        directed = '{
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_A,  3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_B,  3'd0, 3'd0, 32'h0002_0000, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0002_0000, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_A,  3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_B,  3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_A,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'h8000_0000, 1'b1},
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_B,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
            // loads outside the configured sizes and an unknown request
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_A,  3'd0, 3'd1, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_B,  3'd1, 3'd0, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_A,  3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_NONE,    3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
            // -1 LSB times 1 LSB floors to -1 LSB
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_A,  3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_LOAD_B,  3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd1, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0},
            // zero sizes: no rows or no columns emits nothing, no inner terms gives zero
            '{4'd0, 4'd1, 4'd1, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{4'd1, 4'd0, 4'd1, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, 1'b0},
            '{4'd1, 4'd1, 4'd0, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0},
            // register values above the maximum act as the maximum
            '{4'd15, 4'd15, 4'd15, REQ_LOAD_A,  3'd7, 3'd7, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{4'd15, 4'd15, 4'd15, REQ_LOAD_B,  3'd7, 3'd7, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
            '{4'd15, 4'd15, 4'd15, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{4'd9,  4'd3,  4'd12, REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0},
            '{4'd2,  4'd8,  4'd1,  REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[n]) begin
            if (directed[n].rows != rows_reg || directed[n].inner != inner_reg ||
                directed[n].cols != cols_reg)
                set_dims(directed[n].rows, directed[n].inner, directed[n].cols);
            if (directed[n].req == REQ_COMPUTE)
                fill_missing();
            if (directed[n].typed) begin
                typed_product = '{IDX_W'(0), IDX_W'(0), directed[n].want_value,
                                  directed[n].want_sat, 1'b1};
                use_typed = 1'b1;
            end
            send_item(directed[n].req, directed[n].row, directed[n].col, directed[n].value);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
                default: begin src_idle_pct = 12; sink_stall_pct = 12; end
            endcase
            phase_goal = active_items + PHASE_ITEMS;
            set_dims(rand_dim(), rand_dim(), rand_dim());
            while (active_items < phase_goal) begin
                if ($urandom_range(4) == 0)
                    set_dims(rand_dim(), rand_dim(), rand_dim());
                nr = eff_dim(rows_reg);
                nk = eff_dim(inner_reg);
                nc = eff_dim(cols_reg);
                repeat ($urandom_range(6, 1)) begin
                    pick = $urandom_range(9);
                    if (pick < 2) begin
                        // noise: any index, loads or the unknown request
                        pick = $urandom_range(2);
                        send_item((pick == 2) ? REQ_NONE : mm_req_t'(pick),
                                  IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                                  $urandom());
                    end else if (pick < 6 && nr > 0 && nk > 0) begin
                        send_item(REQ_LOAD_A, IDX_W'($urandom_range(nr - 1)),
                                  IDX_W'($urandom_range(nk - 1)), rand_element());
                    end else if (nk > 0 && nc > 0) begin
                        send_item(REQ_LOAD_B, IDX_W'($urandom_range(nk - 1)),
                                  IDX_W'($urandom_range(nc - 1)), rand_element());
                    end
                end
                fill_missing();
                send_item(REQ_COMPUTE, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                          $urandom());
                if ($urandom_range(9) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Run covered %0d computes, %0d product transfers checked, %0d saturated.",
                 compute_count, product_count, sat_count);
        $display("Sizes from zero to above the maximum, four pacing phases, %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
